// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, constants and the log weight table of the trigram word scorer.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int COUNT_BITS    = 8;
   localparam int LOG_ENTRIES   = 256;
   localparam int LETTER_BITS   = 5;
   localparam int FUNC_BITS     = 2;
   localparam int INDEX_BITS    = 15;
   localparam int SCORE_BITS    = 5;
   localparam int WEIGHT_BITS   = 5;
   localparam int ALPHABET      = 27;
   localparam int LAST_LETTER   = 26;
   localparam int DIGRAM_DEPTH  = ALPHABET * ALPHABET;
   localparam int TRIGRAM_DEPTH = ALPHABET * ALPHABET * ALPHABET;
   localparam int DIG_ADDR_BITS = $clog2(DIGRAM_DEPTH);
   localparam int TRI_ADDR_BITS = $clog2(TRIGRAM_DEPTH);
   localparam int NUM_STEPS     = 11;

   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_DIGRAM  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_TRIGRAM = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_SCORE_LETTER = 2'd2;

   localparam logic signed [WEIGHT_BITS-1:0] LOG_FLOOR = -5'sd10;

   // Counts at which the rounded log weight steps up by one.
   localparam logic [COUNT_BITS-1:0] STEP_POINTS [NUM_STEPS] = '{
      8'd5, 8'd11, 8'd23, 8'd43, 8'd68, 8'd96, 8'd126, 8'd156, 8'd187, 8'd217, 8'd248
   };

   // Per-position control that travels down the scoring pipeline.
   typedef struct packed {
      logic valid;
      logic scored;
      logic last_pos;
   } stage_ctrl_type;

   function automatic logic signed [WEIGHT_BITS-1:0] log_weight(
      input logic [COUNT_BITS-1:0] count
   );
      logic [WEIGHT_BITS-1:0] steps;
      steps = WEIGHT_BITS'(1);
      for (int k = 0; k < NUM_STEPS; k++) begin
         if (count >= STEP_POINTS[k]) begin
            steps = steps + WEIGHT_BITS'(1);
         end
      end
      if (count < COUNT_BITS'(2)) begin
         log_weight = LOG_FLOOR;
      end else begin
         log_weight = signed'(steps);
      end
   endfunction

endpackage

// ===== rtl/trigram_word_scorer_core.sv =====
// ----------------------------------------------------------------------------
// trigram_word_scorer_core
// Scores a word by how unusual its letter trigrams are against loaded counts.
// ----------------------------------------------------------------------------
// Load the digram and trigram count tables with func 0 and 1 transfers, then
// send a word one letter per transfer with func 2 and mark its final letter.
// A load or a non-final letter leaves the input ready; the final letter stalls
// it while the padded end position does a second read of both count memories,
// which have one read port each. A word's score is registered by the memories,
// the weight registers and the result register. Results flow past a waiting
// output until a second finished word reaches it, which then stalls the input.
module trigram_word_scorer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tws_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [tws_pkg::INDEX_BITS-1:0]       req_table_index,
   input  logic [tws_pkg::COUNT_BITS-1:0]       req_count_value,
   input  logic [tws_pkg::LETTER_BITS-1:0]      req_letter,
   input  logic                                 req_last_letter,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tws_pkg::SCORE_BITS-1:0]       rsp_word_score
);

   localparam int LB = tws_pkg::LETTER_BITS;
   localparam int DB = tws_pkg::DIG_ADDR_BITS;
   localparam int TB = tws_pkg::TRI_ADDR_BITS;

   logic [LB-1:0] cur_ff, cur_in;
   logic [DB-1:0] pair_ff, pair_in;
   logic          started_ff, started_in;
   logic          pend_ff, pend_in;
   tws_pkg::stage_ctrl_type s1_ff, s1_in;

   logic          hold;
   logic          accept;
   logic          issue_letter;
   logic          issue_end;
   logic          rd_en;
   logic [LB-1:0] letter_clean;
   logic [LB-1:0] letter_sel;
   logic [DB-1:0] dig_raddr;
   logic [TB-1:0] tri_raddr;
   logic          dig_we;
   logic          tri_we;
   logic [tws_pkg::COUNT_BITS-1:0] dig_count;
   logic [tws_pkg::COUNT_BITS-1:0] tri_count;

   assign req_stall    = pend_ff || hold;
   assign accept       = req_valid && !req_stall;
   assign issue_letter = accept && (req_func == tws_pkg::FUNC_SCORE_LETTER);
   assign issue_end    = pend_ff && !hold;
   assign rd_en        = issue_letter || issue_end;

   // Codes above the alphabet count as the padding letter.
   assign letter_clean = (req_letter > LB'(tws_pkg::LAST_LETTER)) ? '0 : req_letter;
   assign letter_sel   = issue_end ? '0 : letter_clean;

   // pair_ff holds the base-27 index of the two most recent letters.
   assign dig_raddr = DB'(cur_ff) * DB'(tws_pkg::ALPHABET) + DB'(letter_sel);
   assign tri_raddr = TB'(pair_ff) * TB'(tws_pkg::ALPHABET) + TB'(letter_sel);

   assign dig_we = accept && (req_func == tws_pkg::FUNC_LOAD_DIGRAM) &&
                   (req_table_index < tws_pkg::INDEX_BITS'(tws_pkg::DIGRAM_DEPTH));
   assign tri_we = accept && (req_func == tws_pkg::FUNC_LOAD_TRIGRAM) &&
                   (req_table_index < tws_pkg::INDEX_BITS'(tws_pkg::TRIGRAM_DEPTH));

   always_comb begin
      cur_in     = cur_ff;
      pair_in    = pair_ff;
      started_in = started_ff;
      pend_in    = pend_ff;
      if (issue_end) begin
         cur_in     = '0;
         pair_in    = '0;
         started_in = 1'b0;
         pend_in    = 1'b0;
      end else if (issue_letter) begin
         cur_in     = letter_clean;
         pair_in    = dig_raddr;
         started_in = 1'b1;
         pend_in    = req_last_letter;
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (!hold) begin
         s1_in.valid    = rd_en;
         s1_in.scored   = issue_end || started_ff;
         s1_in.last_pos = issue_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         pair_ff    <= '0;
         started_ff <= 1'b0;
         pend_ff    <= 1'b0;
         s1_ff      <= '0;
      end else begin
         cur_ff     <= cur_in;
         pair_ff    <= pair_in;
         started_ff <= started_in;
         pend_ff    <= pend_in;
         s1_ff      <= s1_in;
      end
   end

   tws_ram #(
      .WIDTH (tws_pkg::COUNT_BITS),
      .DEPTH (tws_pkg::DIGRAM_DEPTH)
   ) u_digram_ram (
      .clock   (clock),
      .wr_en   (dig_we),
      .wr_addr (req_table_index[DB-1:0]),
      .wr_data (req_count_value),
      .rd_en   (rd_en),
      .rd_addr (dig_raddr),
      .rd_data (dig_count)
   );

   tws_ram #(
      .WIDTH (tws_pkg::COUNT_BITS),
      .DEPTH (tws_pkg::TRIGRAM_DEPTH)
   ) u_trigram_ram (
      .clock   (clock),
      .wr_en   (tri_we),
      .wr_addr (req_table_index[TB-1:0]),
      .wr_data (req_count_value),
      .rd_en   (rd_en),
      .rd_addr (tri_raddr),
      .rd_data (tri_count)
   );

   tws_score u_score (
      .clock          (clock),
      .reset          (reset),
      .s1_ctrl        (s1_ff),
      .dig_count      (dig_count),
      .tri_count      (tri_count),
      .hold           (hold),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_score (rsp_word_score)
   );

endmodule

// ===== rtl/tws_ram.sv =====
// ----------------------------------------------------------------------------
// tws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tws_score.sv =====
// ----------------------------------------------------------------------------
// tws_score
// Log weight lookup, position score, running maximum and result register.
// ----------------------------------------------------------------------------
module tws_score (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tws_pkg::stage_ctrl_type              s1_ctrl,
   input  logic [tws_pkg::COUNT_BITS-1:0]       dig_count,
   input  logic [tws_pkg::COUNT_BITS-1:0]       tri_count,
   output logic                                 hold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tws_pkg::SCORE_BITS-1:0]       rsp_word_score
);

   localparam int W = tws_pkg::WEIGHT_BITS;
   localparam int S = tws_pkg::SCORE_BITS;

   tws_pkg::stage_ctrl_type s2_ff, s2_in;
   logic signed [W-1:0] dig_weight_ff, tri_weight_ff;
   logic signed [W-1:0] prev_weight_ff, prev_weight_in;
   logic [S-1:0]        best_ff, best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]        rsp_score_ff, rsp_score_in;

   logic                s2_fire;
   logic signed [W:0]   pair_sum;
   logic signed [W-1:0] pair_half;
   logic signed [W+1:0] pos_score;
   logic [S-1:0]        new_best;

   // A finished word may not land on a result that is still waiting.
   assign hold    = s2_ff.valid && s2_ff.last_pos && rsp_valid_ff && rsp_stall;
   assign s2_fire = s2_ff.valid && !hold;

   // Arithmetic shift gives the floor of the half sum.
   assign pair_sum  = (W+1)'(prev_weight_ff) + (W+1)'(dig_weight_ff);
   assign pair_half = pair_sum[W:1];
   assign pos_score = (W+2)'(pair_half) - (W+2)'(tri_weight_ff);

   always_comb begin
      new_best = best_ff;
      if (s2_ff.scored && (pos_score > signed'((W+2)'(best_ff)))) begin
         new_best = pos_score[S-1:0];
      end
   end

   always_comb begin
      s2_in          = hold ? s2_ff : s1_ctrl;
      prev_weight_in = prev_weight_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_score_in   = rsp_score_ff;
      if (s2_fire) begin
         prev_weight_in = dig_weight_ff;
         best_in        = new_best;
         if (s2_ff.last_pos) begin
            best_in      = '0;
            rsp_valid_in = 1'b1;
            rsp_score_in = new_best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= s2_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         dig_weight_ff <= tws_pkg::log_weight(dig_count);
         tri_weight_ff <= tws_pkg::log_weight(tri_count);
      end
      prev_weight_ff <= prev_weight_in;
      rsp_score_ff   <= rsp_score_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_score = rsp_score_ff;

endmodule
